@@ hw/rtl/sgr_pkg.sv @@
// ---------------------------------------------------------------------------
// sgr_pkg
// Types, constants and byte-class functions for the Shift-JIS gaiji replacer.
// ---------------------------------------------------------------------------
package sgr_pkg;

  localparam logic [7:0] SPACE_LEAD  = 8'h81;
  localparam logic [7:0] SPACE_TRAIL = 8'h40;

  // Result queue depth; two free slots are needed to take a new byte
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [7:0] out_byte;
    logic       bad_char;
    logic       run_last;
    logic       done_res;
  } res_t;

  // What the decoder hands to the result queue for one accepted word
  typedef struct packed {
    logic [1:0] num;
    res_t       res0;
    res_t       res1;
  } push_t;

  function automatic logic is_single(input logic [7:0] b);
    return ((b >= 8'h01) && (b <= 8'h7F)) || ((b >= 8'hA1) && (b <= 8'hDF));
  endfunction

  function automatic logic is_lead(input logic [7:0] b);
    return ((b >= 8'h81) && (b <= 8'h9F)) || ((b >= 8'hE0) && (b <= 8'hFC));
  endfunction

  function automatic logic is_trail(input logic [7:0] b);
    return ((b >= 8'h40) && (b <= 8'h7E)) || ((b >= 8'h80) && (b <= 8'hFC));
  endfunction

  // Vendor and user-defined code areas
  function automatic logic is_gaiji(input logic [7:0] l, input logic [7:0] t);
    logic g;
    g = 1'b0;
    if (l == 8'h84)                         g = (t >= 8'h92);
    else if ((l >= 8'h85) && (l <= 8'h86))  g = 1'b1;
    else if (l == 8'h87)                    g = (t >= 8'h9D);
    else if (l == 8'h88)                    g = (t <= 8'h9E);
    else if (l == 8'hEA)                    g = (t >= 8'hA5);
    else if ((l >= 8'hEB) && (l <= 8'hEC))  g = 1'b1;
    else if (l == 8'hEE)                    g = (t >= 8'hFD);
    else if ((l >= 8'hEF) && (l <= 8'hFA))  g = 1'b1;
    else if (l == 8'hFC)                    g = (t >= 8'h4B);
    return g;
  endfunction

endpackage

@@ hw/rtl/sgr_if.sv @@
// ---------------------------------------------------------------------------
// sgr_if
// Valid/ready channels for input bytes and result bytes.
// ---------------------------------------------------------------------------
interface sgr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       string_end;

  modport source (output valid, output in_byte, output string_end, input ready);
  modport sink   (input valid, input in_byte, input string_end, output ready);
endinterface

interface sgr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       bad_char;
  logic       run_last;
  logic       done_res;

  modport source (output valid, output out_byte, output bad_char, output run_last,
                  output done_res, input ready);
  modport sink   (input valid, input out_byte, input bad_char, input run_last,
                  input done_res, output ready);
endinterface

@@ hw/rtl/sgr_decode.sv @@
// ---------------------------------------------------------------------------
// sgr_decode
// Classifies each accepted byte, tracks the held lead byte and the sticky
// error, and produces zero, one or two result words.
// ---------------------------------------------------------------------------
module sgr_decode (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  logic [7:0]    in_byte,
  input  logic          string_end,
  output sgr_pkg::push_t push
);
  import sgr_pkg::*;

  logic       lead_pending_r, lead_pending_nxt;
  logic [7:0] held_lead_r,    held_lead_nxt;
  logic       error_seen_r,   error_seen_nxt;
  logic       err;
  res_t       err_res;

  always_comb begin
    push             = '0;
    lead_pending_nxt = lead_pending_r;
    held_lead_nxt    = held_lead_r;
    error_seen_nxt   = error_seen_r;
    err              = 1'b0;
    err_res          = '{out_byte: 8'h00, bad_char: 1'b1, run_last: 1'b1,
                         done_res: string_end};

    if (error_seen_r) begin
      // drop bytes until the end of the string, then flag the end once more
      if (string_end) begin
        push.num  = 2'd1;
        push.res0 = err_res;
      end
    end else if (lead_pending_r) begin
      lead_pending_nxt = 1'b0;
      held_lead_nxt    = 8'h00;
      if (is_trail(in_byte)) begin
        push.num = 2'd2;
        if (is_gaiji(held_lead_r, in_byte)) begin
          push.res0 = '{out_byte: SPACE_LEAD, bad_char: 1'b0, run_last: 1'b0,
                        done_res: 1'b0};
          push.res1 = '{out_byte: SPACE_TRAIL, bad_char: 1'b0, run_last: 1'b1,
                        done_res: string_end};
        end else begin
          push.res0 = '{out_byte: held_lead_r, bad_char: 1'b0, run_last: 1'b0,
                        done_res: 1'b0};
          push.res1 = '{out_byte: in_byte, bad_char: 1'b0, run_last: 1'b1,
                        done_res: string_end};
        end
      end else begin
        err = 1'b1;
      end
    end else if (is_single(in_byte)) begin
      push.num  = 2'd1;
      push.res0 = '{out_byte: in_byte, bad_char: 1'b0, run_last: 1'b1,
                    done_res: string_end};
    end else if (is_lead(in_byte) && !string_end) begin
      lead_pending_nxt = 1'b1;
      held_lead_nxt    = in_byte;
    end else begin
      err = 1'b1;
    end

    if (err) begin
      push.num       = 2'd1;
      push.res0      = err_res;
      error_seen_nxt = 1'b1;
    end

    // end of string: back to the idle state
    if (string_end) begin
      lead_pending_nxt = 1'b0;
      held_lead_nxt    = 8'h00;
      error_seen_nxt   = 1'b0;
    end

    if (!accept) begin
      push.num = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_pending_r <= 1'b0;
      held_lead_r    <= 8'h00;
      error_seen_r   <= 1'b0;
    end else if (accept) begin
      lead_pending_r <= lead_pending_nxt;
      held_lead_r    <= held_lead_nxt;
      error_seen_r   <= error_seen_nxt;
    end
  end

endmodule

@@ hw/rtl/sgr_result_queue.sv @@
// ---------------------------------------------------------------------------
// sgr_result_queue
// Small register queue: takes up to two result words per cycle, gives one per cycle while the output is ready.
// ---------------------------------------------------------------------------
module sgr_result_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  sgr_pkg::push_t push,
  output logic           room,
  output logic           out_valid,
  input  logic           out_ready,
  output sgr_pkg::res_t  out_res
);
  import sgr_pkg::*;

  res_t                 slot_r [QDEPTH];
  logic [QPTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]    wr_ptr_p1;
  logic [QCNT_W-1:0]    count_r, count_nxt;
  logic                 pop;

  assign out_valid = (count_r != '0);
  assign out_res   = slot_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;
  // two free slots cover the worst case of one input byte
  assign room      = (count_r <= QCNT_W'(QDEPTH - 2));
  assign wr_ptr_p1 = wr_ptr_r + QPTR_W'(1);

  always_comb begin
    rd_ptr_nxt = rd_ptr_r + QPTR_W'(pop);
    wr_ptr_nxt = wr_ptr_r + QPTR_W'(push.num);
    count_nxt  = count_r + QCNT_W'(push.num) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.num != 2'd0) begin
      slot_r[wr_ptr_r] <= push.res0;
    end
    if (push.num == 2'd2) begin
      slot_r[wr_ptr_p1] <= push.res1;
    end
  end

endmodule

@@ hw/rtl/sjis_gaiji_replacer.sv @@
// ---------------------------------------------------------------------------
// sjis_gaiji_replacer
// Shift-JIS byte stream checker that replaces gaiji pairs by a full-width
// space.
// ---------------------------------------------------------------------------
// One input byte is taken per cycle whenever the four-entry result queue has
// two free slots. A byte's words are written into the queue registers when
// the byte is accepted. A single-byte character yields one output word and
// a two-byte character two, both pushed with its trail byte, so with the
// output always ready the sustained rate is one input byte per cycle for any
// text; output stalls fill the queue and then hold off the input. A lead byte
// is held inside and gives no result until its trail arrives. Malformed input
// yields one word with bad_char set; the rest of the string is dropped, and
// its final byte yields one more bad_char word with done_res set. Earlier
// words of that string should be discarded.
module sjis_gaiji_replacer (
  input  logic      clk,
  input  logic      rst_n,
  sgr_in_if.sink    in_s,
  sgr_out_if.source out_m
);
  import sgr_pkg::*;

  logic  room;
  logic  accept;
  push_t push;
  res_t  out_res;

  assign in_s.ready = room;
  assign accept     = in_s.valid && room;

  sgr_decode u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .in_byte    (in_s.in_byte),
    .string_end (in_s.string_end),
    .push       (push)
  );

  sgr_result_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_m.valid),
    .out_ready (out_m.ready),
    .out_res   (out_res)
  );

  assign out_m.out_byte = out_res.out_byte;
  assign out_m.bad_char = out_res.bad_char;
  assign out_m.run_last = out_res.run_last;
  assign out_m.done_res = out_res.done_res;

endmodule

@@ sim/sjis_gaiji_replacer_test.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// sjis_gaiji_replacer_test
// Feeds Shift-JIS strings into the replacer and checks every output word
// against a byte-level prediction of pass-through, gaiji replacement and
// malformed-string marking. The input and output sides idle at random, the
// output side also holds off for long stretches, and the run ends with a
// pass or fail line.
// ---------------------------------------------------------------------------
module sjis_gaiji_replacer_test;
  import sgr_pkg::*;

  localparam int          HALF_NS      = 10;
  localparam int          RESET_CYCLES = 12;
  localparam int unsigned MAX_IDLE     = 17;
  localparam int unsigned HOLD_CYCLES  = 60;
  localparam int unsigned BURST_ITEMS  = 40;
  localparam int unsigned RANDOM_ITEMS = 725;
  localparam int unsigned DRAIN_EVERY  = 150;
  localparam int          TAIL_CYCLES  = 20;
  localparam int          TIMEOUT_NS   = 10_000_000;

  typedef struct {
    logic [7:0]  sj_byte;
    logic        eos;
    int unsigned gap;
    bit          drain;
    bit          choke;
  } text_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic       src_valid = 1'b0;
  logic [7:0] src_byte = 8'h00;
  logic       src_end = 1'b0;
  logic       sink_ready = 1'b0;

  sgr_in_if  in_ch ();
  sgr_out_if out_ch ();

  assign in_ch.valid      = src_valid;
  assign in_ch.in_byte    = src_byte;
  assign in_ch.string_end = src_end;
  assign out_ch.ready     = sink_ready;

  sjis_gaiji_replacer uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_s  (in_ch),
    .out_m (out_ch)
  );

  always begin
    #HALF_NS clk = 1'b1;
    #HALF_NS clk = 1'b0;
  end

  // Pending input bytes and the output words they must produce
  text_item_t text_q[$];
  res_t       replaced_q[$];

  // Predicted decoder state
  bit         lead_held = 1'b0;
  logic [7:0] lead_byte = 8'h00;
  bit         err_latched = 1'b0;

  int unsigned idle_left = 0;
  logic        choke_kick = 1'b0;
  int unsigned choke_left = 0;
  int unsigned stall_left = 0;
  bit          sink_calm = 1'b0;

  int unsigned bytes_in = 0;
  int unsigned words_out = 0;
  int unsigned strings_done = 0;
  int unsigned gaiji_hits = 0;
  int unsigned bad_words = 0;
  int unsigned mismatch_cnt = 0;

  task automatic add_word(input logic [7:0] b, input logic bad, input logic last,
                          input logic done);
    res_t w;
    w.out_byte = b;
    w.bad_char = bad;
    w.run_last = last;
    w.done_res = done;
    replaced_q.push_back(w);
  endtask

  task automatic replace_sjis(input logic [7:0] b, input logic eos);
    logic [7:0] lead;
    logic       broken;
    logic       area;
    broken = 1'b0;
    area = 1'b0;
    if (err_latched) begin
      // Drop the rest of a broken string; its final byte marks the end
      if (eos) add_word(8'h00, 1'b1, 1'b1, 1'b1);
    end else if (lead_held) begin
      lead = lead_byte;
      lead_held = 1'b0;
      lead_byte = 8'h00;
      if ((b >= 8'h40 && b <= 8'h7E) || (b >= 8'h80 && b <= 8'hFC)) begin
        case (lead)
          8'h84:        area = (b >= 8'h92);
          8'h85, 8'h86: area = 1'b1;
          8'h87:        area = (b >= 8'h9D);
          8'h88:        area = (b <= 8'h9E);
          8'hEA:        area = (b >= 8'hA5);
          8'hEB, 8'hEC: area = 1'b1;
          8'hEE:        area = (b >= 8'hFD);
          8'hFC:        area = (b >= 8'h4B);
          default:      area = (lead >= 8'hEF) && (lead <= 8'hFA);
        endcase
        if (area) begin
          add_word(SPACE_LEAD, 1'b0, 1'b0, 1'b0);
          add_word(SPACE_TRAIL, 1'b0, 1'b1, eos);
          gaiji_hits++;
        end else begin
          add_word(lead, 1'b0, 1'b0, 1'b0);
          add_word(b, 1'b0, 1'b1, eos);
        end
      end else begin
        broken = 1'b1;
      end
    end else if ((b >= 8'h01 && b <= 8'h7F) || (b >= 8'hA1 && b <= 8'hDF)) begin
      add_word(b, 1'b0, 1'b1, eos);
    end else if (((b >= 8'h81 && b <= 8'h9F) || (b >= 8'hE0 && b <= 8'hFC)) && !eos) begin
      lead_held = 1'b1;
      lead_byte = b;
    end else begin
      broken = 1'b1;
    end
    if (broken) begin
      add_word(8'h00, 1'b1, 1'b1, eos);
      err_latched = 1'b1;
    end
    if (eos) begin
      lead_held = 1'b0;
      lead_byte = 8'h00;
      err_latched = 1'b0;
    end
  endtask

  function automatic int unsigned pick_gap(input bit calm);
    if (calm || $urandom_range(0, 1) == 0) return 0;
    return $urandom_range(0, MAX_IDLE);
  endfunction

  function automatic logic [7:0] rand_single();
    if ($urandom_range(0, 1) == 0) return 8'($urandom_range(8'h01, 8'h7F));
    return 8'($urandom_range(8'hA1, 8'hDF));
  endfunction

  function automatic logic [7:0] rand_lead();
    case ($urandom_range(0, 3))
      0:       return 8'($urandom_range(8'h84, 8'h88));
      1:       return 8'($urandom_range(8'hEA, 8'hFC));
      2:       return 8'($urandom_range(8'h81, 8'h9F));
      default: return 8'($urandom_range(8'hE0, 8'hFC));
    endcase
  endfunction

  function automatic logic [7:0] rand_trail();
    if ($urandom_range(0, 3) == 0) begin
      // Range ends and gaiji boundaries
      case ($urandom_range(0, 13))
        0:       return 8'h40;
        1:       return 8'h7E;
        2:       return 8'h80;
        3:       return 8'hFC;
        4:       return 8'h91;
        5:       return 8'h92;
        6:       return 8'h9C;
        7:       return 8'h9D;
        8:       return 8'h9E;
        9:       return 8'h9F;
        10:      return 8'hA4;
        11:      return 8'hA5;
        12:      return 8'h4A;
        default: return 8'h4B;
      endcase
    end
    if ($urandom_range(0, 1) == 0) return 8'($urandom_range(8'h40, 8'h7E));
    return 8'($urandom_range(8'h80, 8'hFC));
  endfunction

  // Neither single-byte nor lead
  function automatic logic [7:0] rand_bad_byte();
    case ($urandom_range(0, 4))
      0:       return 8'h80;
      1:       return 8'hA0;
      2:       return 8'hFD;
      3:       return 8'hFE;
      default: return 8'hFF;
    endcase
  endfunction

  function automatic logic [7:0] rand_bad_trail();
    case ($urandom_range(0, 2))
      0:       return 8'($urandom_range(8'h01, 8'h3F));
      1:       return 8'h7F;
      default: return 8'($urandom_range(8'hFD, 8'hFF));
    endcase
  endfunction

  task automatic add_text(input logic [7:0] b, input logic eos, input int unsigned gap,
                          input bit drain, input bit choke);
    text_item_t t;
    t.sj_byte = b;
    t.eos = eos;
    t.gap = gap;
    t.drain = drain;
    t.choke = choke;
    text_q.push_back(t);
  endtask

  // Input side: offer queued bytes, honoring per-byte gaps and drain points
  always @(posedge clk) begin : feed
    text_item_t t;
    logic       busy;
    logic       v_next;
    logic       kick;
    busy = src_valid && !in_ch.ready;
    v_next = rst_n ? busy : 1'b0;
    kick = 1'b0;
    if (rst_n && !busy) begin
      if (idle_left != 0) begin
        idle_left = idle_left - 1;
      end else if (text_q.size() != 0) begin
        if (text_q[0].gap != 0) begin
          idle_left = text_q[0].gap - 1;
          text_q[0].gap = 0;
        end else if (!(text_q[0].drain && replaced_q.size() != 0)) begin
          t = text_q.pop_front();
          src_byte <= t.sj_byte;
          src_end <= t.eos;
          v_next = 1'b1;
          kick = t.choke;
        end
      end
    end
    src_valid <= v_next;
    choke_kick <= kick;
  end

  // Long output hold-off, started by a marked input byte
  always @(posedge clk) begin
    if (choke_kick) choke_left <= HOLD_CYCLES;
    else if (choke_left != 0) choke_left <= choke_left - 1;
  end

  // Output side: predict on each accepted byte, check each accepted word
  always @(posedge clk) begin : watch
    res_t got;
    res_t want;
    logic rdy;
    rdy = 1'b0;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        replace_sjis(in_ch.in_byte, in_ch.string_end);
        bytes_in++;
      end
      if (out_ch.valid && out_ch.ready) begin
        got.out_byte = out_ch.out_byte;
        got.bad_char = out_ch.bad_char;
        got.run_last = out_ch.run_last;
        got.done_res = out_ch.done_res;
        if (replaced_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display({"ERROR at %0t: word with nothing predicted:",
                      " byte %02h bad %0b last %0b done %0b"},
                     $time, got.out_byte, got.bad_char, got.run_last, got.done_res);
        end else begin
          want = replaced_q.pop_front();
          if (got.out_byte !== want.out_byte || got.bad_char !== want.bad_char ||
              got.run_last !== want.run_last || got.done_res !== want.done_res) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display({"ERROR at %0t: word %0d expected byte %02h bad %0b last %0b done %0b,",
                        " got byte %02h bad %0b last %0b done %0b"},
                       $time, words_out, want.out_byte, want.bad_char, want.run_last,
                       want.done_res, got.out_byte, got.bad_char, got.run_last, got.done_res);
          end
        end
        if (got.done_res === 1'b1) strings_done++;
        if (got.bad_char === 1'b1) bad_words++;
        words_out++;
        if (words_out % 64 == 0) sink_calm = ($urandom_range(0, 3) == 0);
        stall_left = sink_calm ? 0 : $urandom_range(0, MAX_IDLE);
      end
      if (stall_left != 0) begin
        stall_left = stall_left - 1;
      end else begin
        rdy = (choke_left == 0);
      end
    end
    sink_ready <= rdy;
  end

  initial begin : run
    logic [7:0]  str[$];
    bit          trail_at[$];
    int unsigned fed_plan;
    int unsigned next_drain;
    int unsigned chokes;
    int unsigned burst_left;
    int unsigned shape;
    int unsigned n;
    int unsigned pos;
    int unsigned gap;
    bit          calm;
    bit          drain;
    bit          choke;

    // Single-byte range ends
    add_text(8'h01, 1'b0, 0, 1'b0, 1'b0);
    add_text(8'h7F, 1'b0, 0, 1'b0, 1'b0);
    add_text(8'hA1, 1'b0, 0, 1'b0, 1'b0);
    add_text(8'hDF, 1'b1, 0, 1'b0, 1'b0);
    // Ordinary pairs at the lead and trail range ends
    add_text(8'h81, 1'b0, pick_gap(1'b0), 1'b0, 1'b0);
    add_text(8'h40, 1'b0, pick_gap(1'b0), 1'b0, 1'b0);
    add_text(8'h9F, 1'b0, pick_gap(1'b0), 1'b0, 1'b0);
    add_text(8'hFC, 1'b0, pick_gap(1'b0), 1'b0, 1'b0);
    add_text(8'hE0, 1'b0, pick_gap(1'b0), 1'b0, 1'b0);
    add_text(8'h7E, 1'b1, pick_gap(1'b0), 1'b0, 1'b0);
    // Gaiji pairs replaced by the full-width space
    add_text(8'h84, 1'b0, 0, 1'b0, 1'b0);
    add_text(8'h92, 1'b0, 0, 1'b0, 1'b0);
    add_text(8'h88, 1'b0, 0, 1'b0, 1'b0);
    add_text(8'h9E, 1'b0, 0, 1'b0, 1'b0);
    add_text(8'hFC, 1'b0, 0, 1'b0, 1'b0);
    add_text(8'h4B, 1'b1, 0, 1'b0, 1'b0);
    // Bad byte mid-string: the rest is dropped until the final byte
    add_text(8'hFF, 1'b0, pick_gap(1'b0), 1'b0, 1'b0);
    add_text(8'h41, 1'b0, pick_gap(1'b0), 1'b0, 1'b0);
    add_text(8'h82, 1'b1, pick_gap(1'b0), 1'b0, 1'b0);
    // Bad trail on the final byte
    add_text(8'h81, 1'b0, 0, 1'b0, 1'b0);
    add_text(8'h7F, 1'b1, 0, 1'b0, 1'b0);
    // Lead byte as the final byte, bad byte as the final byte
    add_text(8'hFC, 1'b1, 0, 1'b0, 1'b0);
    add_text(8'h80, 1'b1, 0, 1'b0, 1'b0);
    add_text(8'hA0, 1'b0, 0, 1'b0, 1'b0);
    add_text(8'hFE, 1'b1, 0, 1'b0, 1'b0);

    fed_plan = 0;
    next_drain = 60;
    chokes = 0;
    burst_left = 0;
    while (fed_plan < RANDOM_ITEMS) begin
      str.delete();
      trail_at.delete();
      shape = $urandom_range(0, 9);
      if (shape == 9) begin
        // Raw noise bytes
        n = $urandom_range(1, 6);
        repeat (n) begin
          str.push_back(8'($urandom_range(1, 255)));
          trail_at.push_back(1'b0);
        end
        fed_plan += n;
      end else begin
        n = $urandom_range(1, 8);
        repeat (n) begin
          if ($urandom_range(0, 2) == 0) begin
            str.push_back(rand_single());
            trail_at.push_back(1'b0);
          end else begin
            str.push_back(rand_lead());
            trail_at.push_back(1'b0);
            str.push_back(rand_trail());
            trail_at.push_back(1'b1);
          end
        end
        if (shape == 8) begin
          pos = $urandom_range(0, str.size() - 1);
          str[pos] = trail_at[pos] ? rand_bad_trail() : rand_bad_byte();
          fed_plan += str.size();
        end else begin
          if (shape == 7) begin
            str.push_back(rand_lead());
            trail_at.push_back(1'b0);
          end
          fed_plan += str.size();
        end
      end

      drain = (fed_plan >= next_drain);
      if (drain) next_drain += DRAIN_EVERY;
      choke = !drain && (chokes < 2) && (fed_plan >= 250 + 300 * chokes);
      if (choke) begin
        chokes++;
        burst_left = BURST_ITEMS;
      end
      calm = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < str.size(); i++) begin
        gap = (burst_left != 0) ? 0 : pick_gap(calm);
        if (burst_left != 0) burst_left--;
        if (i == 0 && drain && gap == 0) gap = 1;
        add_text(str[i], (i == str.size() - 1), gap, drain && (i == 0), choke && (i == 0));
      end
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    while (text_q.size() != 0 || src_valid) @(posedge clk);
    while (replaced_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Fed %0d bytes; checked %0d output words over %0d strings.",
             bytes_in, words_out, strings_done);
    $display("Covered %0d gaiji replacements and %0d malformed-string words.",
             gaiji_hits, bad_words);
    if (mismatch_cnt == 0 && replaced_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d bad words, %0d still awaited", mismatch_cnt, replaced_q.size());
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #TIMEOUT_NS;
    $display("Timed out with %0d input bytes queued", text_q.size());
    $display("Mismatches found");
    $finish;
  end

endmodule
